FILE: src/clcd_pkg.sv
// Shared types, constants and the sequencer control store for the character LCD writer.
package clcd_pkg;

    localparam int BLANK_COUNT_DEFAULT = 16;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] CLEAR_INSTR  = 8'h01;
    localparam logic [7:0] SET_DDRAM    = 8'h80;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;

    localparam logic [5:0] LINE_LENGTH_RESET = 6'd16;
    localparam logic [6:0] ROW0_RESET        = 7'd0;
    localparam logic [6:0] ROW1_RESET        = 7'd64;
    localparam logic [6:0] ROW2_RESET        = 7'd20;
    localparam logic [6:0] ROW3_RESET        = 7'd84;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GOTO  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_RAW   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_LENGTH = 3'd0,
        CFG_ROW0_START  = 3'd1,
        CFG_ROW1_START  = 3'd2,
        CFG_ROW2_START  = 3'd3,
        CFG_ROW3_START  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] byte_value;
        logic [7:0] target_col;
        logic [7:0] target_row;
    } in_item_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last;
    } out_item_t;

    // Microcode: byte source, register-select source and sequencing op.
    typedef enum logic [1:0] {
        SRC_ADDR  = 2'd0,
        SRC_BLANK = 2'd1,
        SRC_PRIM  = 2'd2
    } byte_src_t;

    typedef enum logic [1:0] {
        RS_INSTR = 2'd0,
        RS_DATA  = 2'd1,
        RS_PRIM  = 2'd2
    } rs_src_t;

    typedef enum logic [1:0] {
        SEQ_NEXT    = 2'd0,
        SEQ_LOOP    = 2'd1,
        SEQ_BR_PRIM = 2'd2,
        SEQ_END     = 2'd3
    } seq_op_t;

    localparam int UPC_W = 2;

    typedef struct packed {
        byte_src_t         src;
        rs_src_t           rs;
        seq_op_t           op;
        logic [UPC_W-1:0]  next_upc;
    } ucode_word_t;

    localparam logic [UPC_W-1:0] UPC_ADV_ADDR  = 2'd0;
    localparam logic [UPC_W-1:0] UPC_BLANKS    = 2'd1;
    localparam logic [UPC_W-1:0] UPC_ADV_ADDR2 = 2'd2;
    localparam logic [UPC_W-1:0] UPC_PRIMARY   = 2'd3;

    // Row advance: address, blank run, address again, then the primary byte if any.
    function automatic ucode_word_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucode_word_t w;
        unique case (upc)
            UPC_ADV_ADDR:  w = '{SRC_ADDR,  RS_INSTR, SEQ_NEXT,    UPC_BLANKS};
            UPC_BLANKS:    w = '{SRC_BLANK, RS_DATA,  SEQ_LOOP,    UPC_ADV_ADDR2};
            UPC_ADV_ADDR2: w = '{SRC_ADDR,  RS_INSTR, SEQ_BR_PRIM, UPC_PRIMARY};
            UPC_PRIMARY:   w = '{SRC_PRIM,  RS_PRIM,  SEQ_END,     UPC_PRIMARY};
        endcase
        return w;
    endfunction

endpackage

FILE: src/char_lcd_cursor_nibble_writer_unit.sv
// Character LCD writer: cursor tracking and a microcoded nibble sequencer.
// An accepted item is registered into the sequencer, then its first nibble into m_data.
// Throughput: one nibble per cycle while m_ready does not stall; the input is not ready
// again until its last nibble is registered; a row wrap with a byte sends 38 nibbles by default.
// An item that sends nothing leaves the input ready; an m_ready stall holds the sequencer.
// Reset (aresetn low, synchronous) clears cursor, sequencer and output valid, loads defaults.
module char_lcd_cursor_nibble_writer_unit #(
    parameter int BLANK_COUNT = clcd_pkg::BLANK_COUNT_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  clcd_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output clcd_pkg::out_item_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import clcd_pkg::*;

    localparam int CNT_W = (BLANK_COUNT > 1) ? $clog2(BLANK_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLANK_COUNT - 1);

    // Configuration registers
    logic [5:0] line_length_reg;
    logic [6:0] row_start_reg [4];

    // Cursor
    logic [7:0] cursor_col_reg, cursor_col_next;
    logic [1:0] cursor_row_reg, cursor_row_next;

    // Sequencer
    logic             busy_reg, busy_next;
    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       adv_addr_reg, adv_addr_next;
    logic [7:0]       prim_byte_reg, prim_byte_next;
    logic             prim_rs_reg, prim_rs_next;
    logic             has_prim_reg, has_prim_next;

    // Output register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic        accept;
    logic        out_free;
    logic        need_adv;
    logic [1:0]  rd_row;
    logic [6:0]  rd_start;
    ucode_word_t uw;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic        cur_end;

    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg  <= LINE_LENGTH_RESET;
            row_start_reg[0] <= ROW0_RESET;
            row_start_reg[1] <= ROW1_RESET;
            row_start_reg[2] <= ROW2_RESET;
            row_start_reg[3] <= ROW3_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LINE_LENGTH: line_length_reg  <= cfg_data[5:0];
                CFG_ROW0_START:  row_start_reg[0] <= cfg_data;
                CFG_ROW1_START:  row_start_reg[1] <= cfg_data;
                CFG_ROW2_START:  row_start_reg[2] <= cfg_data;
                CFG_ROW3_START:  row_start_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // One row-start read per item: the target row for a go-to, else the next row.
    assign rd_row   = (s_data.cmd == CMD_GOTO) ? s_data.target_row[1:0] : cursor_row_reg + 2'd1;
    assign rd_start = row_start_reg[rd_row];

    // Decode the accepted item into cursor updates and the bytes to send.
    always_comb begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        need_adv        = 1'b0;
        has_prim_next   = has_prim_reg;
        prim_byte_next  = prim_byte_reg;
        prim_rs_next    = prim_rs_reg;
        adv_addr_next   = adv_addr_reg;
        if (accept) begin
            adv_addr_next = SET_DDRAM | {1'b0, rd_start};
            has_prim_next = 1'b0;
            unique case (s_data.cmd)
                CMD_PUT: begin
                    if (s_data.byte_value == NEWLINE_CODE) begin
                        if (cursor_col_reg == 8'd0) begin
                            need_adv        = 1'b1;
                            cursor_row_next = cursor_row_reg + 2'd1;
                        end
                    end else begin
                        has_prim_next  = 1'b1;
                        prim_byte_next = s_data.byte_value;
                        prim_rs_next   = 1'b1;
                        if (cursor_col_reg == {2'b00, line_length_reg}) begin
                            need_adv        = 1'b1;
                            cursor_row_next = cursor_row_reg + 2'd1;
                            cursor_col_next = 8'd1;
                        end else begin
                            cursor_col_next = cursor_col_reg + 8'd1;
                        end
                    end
                end
                CMD_GOTO: begin
                    cursor_col_next = s_data.target_col;
                    if (s_data.target_row <= 8'd3) begin
                        has_prim_next   = 1'b1;
                        prim_byte_next  = SET_DDRAM + {1'b0, rd_start} + s_data.target_col;
                        prim_rs_next    = 1'b0;
                        cursor_row_next = s_data.target_row[1:0];
                    end
                end
                CMD_CLEAR: begin
                    has_prim_next   = 1'b1;
                    prim_byte_next  = CLEAR_INSTR;
                    prim_rs_next    = 1'b0;
                    cursor_col_next = 8'd0;
                    cursor_row_next = 2'd0;
                end
                CMD_RAW: begin
                    has_prim_next  = 1'b1;
                    prim_byte_next = s_data.byte_value;
                    prim_rs_next   = 1'b0;
                end
            endcase
        end
    end

    assign uw = ucode_rom(upc_reg);

    always_comb begin
        unique case (uw.src)
            SRC_ADDR:  cur_byte = adv_addr_reg;
            SRC_BLANK: cur_byte = BLANK_CHAR;
            SRC_PRIM:  cur_byte = prim_byte_reg;
            default:   cur_byte = prim_byte_reg;
        endcase
        unique case (uw.rs)
            RS_INSTR: cur_rs = 1'b0;
            RS_DATA:  cur_rs = 1'b1;
            RS_PRIM:  cur_rs = prim_rs_reg;
            default:  cur_rs = prim_rs_reg;
        endcase
        cur_end = (uw.op == SEQ_END) || ((uw.op == SEQ_BR_PRIM) && !has_prim_reg);
    end

    // Sequencer stepping and the output register: one nibble beat per free cycle.
    always_comb begin
        busy_next    = busy_reg;
        upc_next     = upc_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (out_free) begin
            m_valid_next = busy_reg;
            if (busy_reg) begin
                m_data_next.reg_select = cur_rs;
                m_data_next.nibble     = phase_reg ? cur_byte[3:0] : cur_byte[7:4];
                m_data_next.last       = phase_reg && cur_end;
                phase_next             = !phase_reg;
                if (phase_reg) begin
                    unique case (uw.op)
                        SEQ_NEXT: upc_next = uw.next_upc;
                        SEQ_LOOP: begin
                            if (cnt_reg == CNT_LAST) begin
                                upc_next = uw.next_upc;
                                cnt_next = '0;
                            end else begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        SEQ_BR_PRIM: begin
                            if (has_prim_reg) begin
                                upc_next = uw.next_upc;
                            end else begin
                                busy_next = 1'b0;
                            end
                        end
                        SEQ_END: busy_next = 1'b0;
                    endcase
                end
            end
        end

        if (accept && (need_adv || has_prim_next)) begin
            busy_next  = 1'b1;
            upc_next   = need_adv ? UPC_ADV_ADDR : UPC_PRIMARY;
            phase_next = 1'b0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 2'd0;
            busy_reg       <= 1'b0;
            upc_reg        <= UPC_PRIMARY;
            phase_reg      <= 1'b0;
            cnt_reg        <= '0;
            has_prim_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            busy_reg       <= busy_next;
            upc_reg        <= upc_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            has_prim_reg   <= has_prim_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        adv_addr_reg  <= adv_addr_next;
        prim_byte_reg <= prim_byte_next;
        prim_rs_reg   <= prim_rs_next;
        m_data_reg    <= m_data_next;
    end

endmodule

FILE: src/clcd_checker.sv
// Port-level checker for the character LCD writer and its bind statement.
module clcd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input clcd_pkg::out_item_t m_data
);
    import clcd_pkg::*;

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // While a beat that is not the last of its item is shown, no new item is taken.
    a_not_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("input ready while an item is still being sent");

    // Ready only drops right after an item was taken.
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("input ready dropped without an accepted item");

    // Reset leaves no result beat pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind char_lcd_cursor_nibble_writer_unit clcd_checker u_clcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/char_lcd_cursor_nibble_writer_unit_tb.sv
// Self-checking testbench for the character LCD cursor and nibble writer.
`timescale 1ns / 100ps

module char_lcd_cursor_nibble_writer_unit_tb;
    import clcd_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 300;

    // Tracks the cursor and the register settings, and queues the bus transfers each
    // accepted command must produce.
    class nibble_scoreboard;
        logic [5:0] line_len;
        logic [6:0] row_base [4];
        logic [7:0] col;
        logic [1:0] row;
        out_item_t  pending [$];
        int         errors;

        function new();
            line_len = LINE_LENGTH_RESET;
            row_base[0] = ROW0_RESET;
            row_base[1] = ROW1_RESET;
            row_base[2] = ROW2_RESET;
            row_base[3] = ROW3_RESET;
            col = '0;
            row = '0;
            errors = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [6:0] val);
            case (idx)
                CFG_LINE_LENGTH: line_len = val[5:0];
                CFG_ROW0_START:  row_base[0] = val;
                CFG_ROW1_START:  row_base[1] = val;
                CFG_ROW2_START:  row_base[2] = val;
                CFG_ROW3_START:  row_base[3] = val;
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic rs);
            out_item_t t;
            t.reg_select = rs;
            t.last = 1'b0;
            t.nibble = b[7:4];
            pending.push_back(t);
            t.nibble = b[3:0];
            pending.push_back(t);
        endfunction

        // Move to the next row, set its address, blank it and set the address again.
        function void advance_row();
            logic [1:0] next_row;
            logic [7:0] addr;
            next_row = row + 2'd1;
            addr = SET_DDRAM | {1'b0, row_base[next_row]};
            push_byte(addr, 1'b0);
            repeat (BLANK_COUNT_DEFAULT) push_byte(BLANK_CHAR, 1'b1);
            push_byte(addr, 1'b0);
            row = next_row;
            col = '0;
        endfunction

        function void note_command(in_item_t c);
            int queued_before;
            logic [7:0] addr;
            queued_before = pending.size();
            case (c.cmd)
                CMD_PUT: begin
                    if (c.byte_value == NEWLINE_CODE) begin
                        if (col == 8'd0) advance_row();
                    end else begin
                        // Only an exact match wraps; a column already past the line keeps going.
                        if (col == {2'b00, line_len}) advance_row();
                        push_byte(c.byte_value, 1'b1);
                        col = col + 8'd1;
                    end
                end
                CMD_GOTO: begin
                    if (c.target_row <= 8'd3) begin
                        addr = SET_DDRAM + {1'b0, row_base[c.target_row[1:0]]} + c.target_col;
                        push_byte(addr, 1'b0);
                        row = c.target_row[1:0];
                    end
                    col = c.target_col;
                end
                CMD_CLEAR: begin
                    push_byte(CLEAR_INSTR, 1'b0);
                    col = '0;
                    row = '0;
                end
                default: push_byte(c.byte_value, 1'b0);
            endcase
            if (pending.size() > queued_before) pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void report(string what, int want, int got);
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        endfunction

        function void check_nibble(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                report("unexpected beat (nothing pending)", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.reg_select !== want.reg_select)
                report("reg_select", want.reg_select, got.reg_select);
            if (got.nibble !== want.nibble)
                report("nibble", want.nibble, got.nibble);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    nibble_scoreboard sb = new();
    bit send_idle_on;
    bit sink_idle_on;
    int hold_requests;

    char_lcd_cursor_nibble_writer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_command(s_data);
            if (m_valid && m_ready) sb.check_nibble(m_data);
        end
    end

    // Result side: random stalls while sink idling is on, plus a long hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        int stall_left;
        int holds_served;
        stall_left = 0;
        holds_served = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (sink_idle_on) begin
                m_ready <= ($urandom_range(99) >= 29);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic in_item_t cmd_item(cmd_t cmd, logic [7:0] bv, logic [7:0] tc,
                                          logic [7:0] tr);
        in_item_t c;
        c.cmd = cmd;
        c.byte_value = bv;
        c.target_col = tc;
        c.target_row = tr;
        return c;
    endfunction

    // Mostly characters, with jumps to the line end so that wraps happen at any length.
    function automatic in_item_t random_command(logic [5:0] ll);
        in_item_t c;
        int pick;
        c.byte_value = 8'($urandom);
        c.target_col = 8'($urandom);
        c.target_row = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 62) begin
            c.cmd = CMD_PUT;
            if ($urandom_range(9) == 0) c.byte_value = NEWLINE_CODE;
        end else if (pick < 80) begin
            c.cmd = CMD_GOTO;
            if ($urandom_range(4) != 0) c.target_row = 8'($urandom_range(3));
            case ($urandom_range(3))
                0: c.target_col = {2'b00, ll} - 8'd1;
                1: c.target_col = {2'b00, ll};
                2: c.target_col = 8'd0;
                default: ;
            endcase
        end else if (pick < 88) begin
            c.cmd = CMD_CLEAR;
        end else begin
            c.cmd = CMD_RAW;
        end
        return c;
    endfunction

    // Valid stays high from one command to the next unless an idle cycle is taken.
    task automatic send_command(input in_item_t item);
        if (send_idle_on) begin
            while ($urandom_range(99) < 29) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_registers(input logic [5:0] ll, input logic [6:0] r0,
                                   input logic [6:0] r1, input logic [6:0] r2,
                                   input logic [6:0] r3);
        cfg_index_t idx [5];
        logic [6:0] vals [5];
        idx = '{CFG_LINE_LENGTH, CFG_ROW0_START, CFG_ROW1_START, CFG_ROW2_START,
                CFG_ROW3_START};
        vals = '{{1'b0, ll}, r0, r1, r2, r3};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit with_hold);
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 3) hold_requests++;
            send_command(random_command(sb.line_len));
        end
    endtask

    // Let the last commands drain so the block is idle before registers change.
    task automatic finish_phase();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : stimulus
        in_item_t directed [$];
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_LINE_LENGTH;
        cfg_data <= '0;
        send_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        hold_requests = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: line length 16, rows at 0, 64, 20 and 84.
        directed = '{
            cmd_item(CMD_CLEAR, 8'h00, 8'h00, 8'h00),
            cmd_item(CMD_PUT,   NEWLINE_CODE, 8'h00, 8'h00),   // newline at column 0 advances
            cmd_item(CMD_PUT,   8'h41, 8'h00, 8'h00),
            cmd_item(CMD_PUT,   NEWLINE_CODE, 8'hFF, 8'hFF),   // ignored away from column 0
            cmd_item(CMD_PUT,   8'h00, 8'h00, 8'h00),
            cmd_item(CMD_PUT,   8'hFF, 8'hFF, 8'hFF),
            cmd_item(CMD_GOTO,  8'h00, 8'd16, 8'd0),
            cmd_item(CMD_PUT,   8'h5A, 8'h00, 8'h00),          // wraps at the line end
            cmd_item(CMD_GOTO,  8'h00, 8'd0, 8'd3),
            cmd_item(CMD_PUT,   NEWLINE_CODE, 8'h00, 8'h00),   // row 3 wraps to row 0
            cmd_item(CMD_GOTO,  8'h00, 8'd255, 8'd255),        // bad row: cursor only
            cmd_item(CMD_PUT,   8'h7E, 8'h00, 8'h00),          // past the line, column wraps
            cmd_item(CMD_PUT,   8'h30, 8'h00, 8'h00),
            cmd_item(CMD_GOTO,  8'h00, 8'd255, 8'd2),          // address wraps past 255
            cmd_item(CMD_GOTO,  8'h00, 8'd16, 8'd4),
            cmd_item(CMD_PUT,   8'h31, 8'h00, 8'h00),
            cmd_item(CMD_RAW,   8'h00, 8'h00, 8'h00),
            cmd_item(CMD_RAW,   8'hFF, 8'hFF, 8'hFF),
            cmd_item(CMD_GOTO,  8'h00, 8'd200, 8'd1),
            cmd_item(CMD_PUT,   NEWLINE_CODE, 8'h00, 8'h00),
            cmd_item(CMD_PUT,   8'h20, 8'h00, 8'h00),
            cmd_item(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF)
        };
        foreach (directed[i]) send_command(directed[i]);
        finish_phase();

        write_registers(6'd40, 7'd127, 7'd0, 7'd127, 7'd0);
        run_random(70, 1'b0);
        finish_phase();

        // A stretch with no idling on either side.
        send_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        write_registers(6'd16, 7'd0, 7'd127, 7'd0, 7'd127);
        run_random(70, 1'b0);
        finish_phase();

        send_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        write_registers(6'($urandom_range(40, 16)), 7'($urandom), 7'($urandom),
                        7'($urandom), 7'($urandom));
        run_random(70, 1'b1);
        finish_phase();

        write_registers(6'($urandom_range(40, 16)), 7'($urandom), 7'($urandom),
                        7'($urandom), 7'($urandom));
        run_random(70, 1'b0);
        finish_phase();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
src/clcd_pkg.sv
src/char_lcd_cursor_nibble_writer_unit.sv
src/clcd_checker.sv
tb/char_lcd_cursor_nibble_writer_unit_tb.sv
